/* hdl/dhfk_pkg.sv */
// Shared types, link constants and fixed-point helpers for the six-axis
// forward kinematics pipeline. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package dhfk_pkg;

    localparam int NUM_JOINTS    = 6;
    localparam int CORDIC_STEPS  = 20;
    localparam int CORDIC_STAGES = CORDIC_STEPS / 2;

    typedef logic signed [15:0] angle_t;
    typedef angle_t [0:NUM_JOINTS-1] angle_vec_t;
    typedef logic signed [31:0] q30_t;
    typedef logic signed [33:0] q30w_t;
    typedef logic signed [63:0] q60_t;
    typedef logic signed [17:0] rot_t;
    typedef logic signed [18:0] pos_t;

    typedef q30_t [0:2] q30_row_t;
    typedef q30_row_t [0:2] q30_mat_t;
    typedef q30w_t [0:2] q30w_vec_t;

    typedef struct packed {
        q30_t x;
        q30_t y;
        q30_t z;
    } cordic_t;

    typedef struct packed {
        q30_t s;
        q30_t c;
        q30_t p0;
        q30_t p1;
    } trig_t;

    typedef trig_t [0:NUM_JOINTS-1] trig_vec_t;

    localparam q30_t ONE_Q30     = 32'sh4000_0000;
    localparam q30_t CORDIC_GAIN = 32'sd652032874;

    localparam q30_t ATAN_TAB [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
        32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
        32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
        32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518
    };

    // Link offsets d and lengths a in Q30 meters.
    localparam q30_t LINK_D [NUM_JOINTS] = '{
        32'sd136687334, 32'sd0, 32'sd0, 32'sd175986285, 32'sd124231929, 32'sd98998996
    };
    localparam q30_t LINK_A [NUM_JOINTS] = '{
        32'sd0, -32'sd657129996, -32'sd614502446, 32'sd0, 32'sd0, 32'sd0
    };

    // Link twist codes: no twist, plus a quarter turn, minus a quarter turn.
    localparam logic [1:0] TWIST_NONE = 2'd0;
    localparam logic [1:0] TWIST_POS  = 2'd1;
    localparam logic [1:0] TWIST_NEG  = 2'd2;
    localparam logic [1:0] LINK_TWIST [NUM_JOINTS] = '{
        TWIST_POS, TWIST_NONE, TWIST_NONE, TWIST_POS, TWIST_NEG, TWIST_NONE
    };

    // Product slots computed per row in a link's multiply stage.
    localparam int NUM_PROD = 7;
    localparam int PR_R0C   = 0;
    localparam int PR_R1S   = 1;
    localparam int PR_R0S   = 2;
    localparam int PR_R1C   = 3;
    localparam int PR_R0P0  = 4;
    localparam int PR_R1P1  = 5;
    localparam int PR_R2D   = 6;

    localparam q30_mat_t IDENT_MAT = '{
        '{ONE_Q30, 32'sd0, 32'sd0},
        '{32'sd0, ONE_Q30, 32'sd0},
        '{32'sd0, 32'sd0, ONE_Q30}
    };

    localparam logic signed [19:0] ROT_MAX = 20'sd65536;
    localparam logic signed [19:0] ROT_MIN = -20'sd65536;
    localparam logic signed [19:0] POS_MAX = 20'sd262143;
    localparam logic signed [19:0] POS_MIN = -20'sd262144;

    // Full Q60 product of two Q30 values.
    function automatic q60_t mul_q30(input q30_t a, input q30_t b);
        return q60_t'(a) * q60_t'(b);
    endfunction

    // Round half up from Q60 to Q30.
    function automatic q60_t rnd30(input q60_t v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    // One rotation-mode CORDIC iteration with floor shifts.
    function automatic cordic_t cordic_iter(input cordic_t v, input int step);
        cordic_t o;
        q30_t xs;
        q30_t ys;
        xs = v.x >>> step;
        ys = v.y >>> step;
        if (!v.z[31])
        begin
            o.x = v.x - ys;
            o.y = v.y + xs;
            o.z = v.z - ATAN_TAB[step];
        end
        else
        begin
            o.x = v.x + ys;
            o.y = v.y - xs;
            o.z = v.z + ATAN_TAB[step];
        end
        return o;
    endfunction

    // Q30 to Q16 with rounding, clamped to plus or minus one.
    function automatic rot_t clamp_rot(input q30_t v);
        logic signed [19:0] r;
        r = 20'((v + 32'sd8192) >>> 14);
        if (r > ROT_MAX)
            r = ROT_MAX;
        else if (r < ROT_MIN)
            r = ROT_MIN;
        return rot_t'(r);
    endfunction

    // Q30 to Q2.16 with rounding and saturation.
    function automatic pos_t sat_pos(input q30w_t v);
        logic signed [19:0] r;
        r = 20'((v + 34'sd8192) >>> 14);
        if (r > POS_MAX)
            r = POS_MAX;
        else if (r < POS_MIN)
            r = POS_MIN;
        return pos_t'(r);
    endfunction

endpackage

/* hdl/dhfk_if.sv */
// Channel interfaces: joint angle vector in, tool pose out.
// Depends on dhfk_pkg for the field types.
`timescale 1ns / 1ps

interface dhfk_joint_if;
    logic            valid;
    logic            ready;
    dhfk_pkg::angle_t joint1_angle;
    dhfk_pkg::angle_t joint2_angle;
    dhfk_pkg::angle_t joint3_angle;
    dhfk_pkg::angle_t joint4_angle;
    dhfk_pkg::angle_t joint5_angle;
    dhfk_pkg::angle_t joint6_angle;

    modport source (
        output valid, joint1_angle, joint2_angle, joint3_angle,
        output joint4_angle, joint5_angle, joint6_angle,
        input  ready
    );
    modport sink (
        input  valid, joint1_angle, joint2_angle, joint3_angle,
        input  joint4_angle, joint5_angle, joint6_angle,
        output ready
    );
endinterface

interface dhfk_pose_if;
    logic           valid;
    logic           ready;
    dhfk_pkg::rot_t rot_00;
    dhfk_pkg::rot_t rot_01;
    dhfk_pkg::rot_t rot_02;
    dhfk_pkg::rot_t rot_10;
    dhfk_pkg::rot_t rot_11;
    dhfk_pkg::rot_t rot_12;
    dhfk_pkg::rot_t rot_20;
    dhfk_pkg::rot_t rot_21;
    dhfk_pkg::rot_t rot_22;
    dhfk_pkg::pos_t pos_x;
    dhfk_pkg::pos_t pos_y;
    dhfk_pkg::pos_t pos_z;

    modport source (
        output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
        output rot_20, rot_21, rot_22, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
        input  rot_20, rot_21, rot_22, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

/* hdl/dhfk_sincos.sv */
// Six-lane pipelined CORDIC: sine, cosine and the in-plane link offsets
// for every joint. Depends on dhfk_pkg.
`timescale 1ns / 1ps

module dhfk_sincos (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   angle_valid,
    output logic                   angle_ready,
    input  dhfk_pkg::angle_vec_t   angle,
    output logic                   trig_valid,
    input  logic                   trig_ready,
    output dhfk_pkg::trig_vec_t    trig
);
    import dhfk_pkg::*;

    // Stage 0 prepares, stages 1..10 iterate twice each, then negate, then scale.
    localparam int NEG_STAGE = CORDIC_STAGES + 1;
    localparam int NUM_STAGE = CORDIC_STAGES + 3;

    logic      vld_reg  [NUM_STAGE];
    logic      en       [NUM_STAGE];
    cordic_t   cr_reg   [CORDIC_STAGES+1][NUM_JOINTS];
    logic [NUM_JOINTS-1:0] flip_reg [CORDIC_STAGES+1];
    q30_t      s_reg    [NUM_JOINTS];
    q30_t      c_reg    [NUM_JOINTS];
    trig_vec_t trig_reg;

    // A stage may load when it is empty or the stage after it moves.
    genvar k;
    generate
        for (k = 0; k < NUM_STAGE; k++)
        begin : g_en
            if (k == NUM_STAGE - 1)
            begin : g_last
                assign en[k] = !vld_reg[k] || trig_ready;
            end
            else
            begin : g_mid
                assign en[k] = !vld_reg[k] || en[k+1];
            end
        end
    endgenerate

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGE; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= angle_valid;
            for (int i = 1; i < NUM_STAGE; i++)
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Angle prep moves quadrants two and three by half a turn; the later
    // stages run two CORDIC iterations each.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int l = 0; l < NUM_JOINTS; l++)
            begin
                cr_reg[0][l].x <= CORDIC_GAIN;
                cr_reg[0][l].y <= '0;
                cr_reg[0][l].z <= {angle[l][14], angle[l][14:0], 16'h0000};
                flip_reg[0][l] <= angle[l][15] ^ angle[l][14];
            end
        end
        for (int i = 1; i <= CORDIC_STAGES; i++)
        begin
            if (en[i])
            begin
                for (int l = 0; l < NUM_JOINTS; l++)
                    cr_reg[i][l] <= cordic_iter(cordic_iter(cr_reg[i-1][l], 2*i-2), 2*i-1);
                flip_reg[i] <= flip_reg[i-1];
            end
        end
    end

    // Undo the half-turn move by negating both results.
    always_ff @(posedge clk)
    begin
        if (en[NEG_STAGE])
        begin
            for (int l = 0; l < NUM_JOINTS; l++)
            begin
                s_reg[l] <= flip_reg[CORDIC_STAGES][l] ? -cr_reg[CORDIC_STAGES][l].y
                                                       : cr_reg[CORDIC_STAGES][l].y;
                c_reg[l] <= flip_reg[CORDIC_STAGES][l] ? -cr_reg[CORDIC_STAGES][l].x
                                                       : cr_reg[CORDIC_STAGES][l].x;
            end
        end
    end

    // Link length times cosine and sine, rounded to Q30.
    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGE-1])
        begin
            for (int l = 0; l < NUM_JOINTS; l++)
            begin
                trig_reg[l].s  <= s_reg[l];
                trig_reg[l].c  <= c_reg[l];
                trig_reg[l].p0 <= q30_t'(rnd30(mul_q30(LINK_A[l], c_reg[l])));
                trig_reg[l].p1 <= q30_t'(rnd30(mul_q30(LINK_A[l], s_reg[l])));
            end
        end
    end

    assign angle_ready = en[0];
    assign trig_valid  = vld_reg[NUM_STAGE-1];
    assign trig        = trig_reg;

endmodule

/* hdl/dhfk_chain.sv */
// Chain of six link stages that multiply the running base-to-link pose by
// each link transform: a multiply stage and a sum stage per link. Depends on dhfk_pkg.
`timescale 1ns / 1ps

module dhfk_chain (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  trig_valid,
    output logic                  trig_ready,
    input  dhfk_pkg::trig_vec_t   trig,
    output logic                  pose_valid,
    input  logic                  pose_ready,
    output dhfk_pkg::q30_mat_t    rot,
    output dhfk_pkg::q30w_vec_t   pos
);
    import dhfk_pkg::*;

    logic      m_vld_reg  [NUM_JOINTS];
    q60_t      m_prod_reg [NUM_JOINTS][3][NUM_PROD];
    q30_t      m_r2_reg   [NUM_JOINTS][3];
    q30w_vec_t m_t_reg    [NUM_JOINTS];
    trig_vec_t m_trig_reg [NUM_JOINTS];

    logic      a_vld_reg  [NUM_JOINTS];
    q30_mat_t  a_r_reg    [NUM_JOINTS];
    q30w_vec_t a_t_reg    [NUM_JOINTS];
    trig_vec_t a_trig_reg [NUM_JOINTS];

    logic      m_en       [NUM_JOINTS];
    logic      a_en       [NUM_JOINTS];
    logic      src_vld    [NUM_JOINTS];
    q30_mat_t  src_r      [NUM_JOINTS];
    q30w_vec_t src_t      [NUM_JOINTS];
    trig_vec_t src_trig   [NUM_JOINTS];

    genvar j;
    generate
        for (j = 0; j < NUM_JOINTS; j++)
        begin : g_link
            q30_mat_t  r_next;
            q30w_vec_t t_next;

            // The first link starts from the identity pose at the origin.
            if (j == 0)
            begin : g_src_first
                assign src_vld[j]  = trig_valid;
                assign src_r[j]    = IDENT_MAT;
                assign src_t[j]    = '0;
                assign src_trig[j] = trig;
            end
            else
            begin : g_src_prev
                assign src_vld[j]  = a_vld_reg[j-1];
                assign src_r[j]    = a_r_reg[j-1];
                assign src_t[j]    = a_t_reg[j-1];
                assign src_trig[j] = a_trig_reg[j-1];
            end

            // Stage enables ripple back from the output.
            if (j == NUM_JOINTS - 1)
            begin : g_en_last
                assign a_en[j] = !a_vld_reg[j] || pose_ready;
            end
            else
            begin : g_en_mid
                assign a_en[j] = !a_vld_reg[j] || m_en[j+1];
            end
            assign m_en[j] = !m_vld_reg[j] || a_en[j];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    m_vld_reg[j] <= 1'b0;
                    a_vld_reg[j] <= 1'b0;
                end
                else
                begin
                    if (m_en[j])
                        m_vld_reg[j] <= src_vld[j];
                    if (a_en[j])
                        a_vld_reg[j] <= m_vld_reg[j];
                end
            end

            // Multiply stage: every nonzero product of one row with the link.
            always_ff @(posedge clk)
            begin
                if (m_en[j])
                begin
                    for (int m = 0; m < 3; m++)
                    begin
                        m_prod_reg[j][m][PR_R0C]  <= mul_q30(src_r[j][m][0], src_trig[j][j].c);
                        m_prod_reg[j][m][PR_R1S]  <= mul_q30(src_r[j][m][1], src_trig[j][j].s);
                        m_prod_reg[j][m][PR_R0S]  <= mul_q30(src_r[j][m][0], src_trig[j][j].s);
                        m_prod_reg[j][m][PR_R1C]  <= mul_q30(src_r[j][m][1], src_trig[j][j].c);
                        m_prod_reg[j][m][PR_R0P0] <= mul_q30(src_r[j][m][0], src_trig[j][j].p0);
                        m_prod_reg[j][m][PR_R1P1] <= mul_q30(src_r[j][m][1], src_trig[j][j].p1);
                        m_prod_reg[j][m][PR_R2D]  <= mul_q30(src_r[j][m][2], LINK_D[j]);
                        m_r2_reg[j][m]            <= src_r[j][m][2];
                    end
                    m_t_reg[j]    <= src_t[j];
                    m_trig_reg[j] <= src_trig[j];
                end
            end

            // Sum stage: round each row sum, place columns by the link twist.
            always_comb
            begin
                for (int m = 0; m < 3; m++)
                begin
                    r_next[m][0] = q30_t'(rnd30(m_prod_reg[j][m][PR_R0C]
                                               + m_prod_reg[j][m][PR_R1S]));
                    case (LINK_TWIST[j])
                        TWIST_POS:
                        begin
                            r_next[m][1] = m_r2_reg[j][m];
                            r_next[m][2] = q30_t'(rnd30(m_prod_reg[j][m][PR_R0S]
                                                       - m_prod_reg[j][m][PR_R1C]));
                        end
                        TWIST_NEG:
                        begin
                            r_next[m][1] = -m_r2_reg[j][m];
                            r_next[m][2] = q30_t'(rnd30(m_prod_reg[j][m][PR_R1C]
                                                       - m_prod_reg[j][m][PR_R0S]));
                        end
                        default:
                        begin
                            r_next[m][1] = q30_t'(rnd30(m_prod_reg[j][m][PR_R1C]
                                                       - m_prod_reg[j][m][PR_R0S]));
                            r_next[m][2] = m_r2_reg[j][m];
                        end
                    endcase
                    t_next[m] = m_t_reg[j][m]
                              + q30w_t'(rnd30(m_prod_reg[j][m][PR_R0P0]
                                              + m_prod_reg[j][m][PR_R1P1]
                                              + m_prod_reg[j][m][PR_R2D]));
                end
            end

            always_ff @(posedge clk)
            begin
                if (a_en[j])
                begin
                    a_r_reg[j]    <= r_next;
                    a_t_reg[j]    <= t_next;
                    a_trig_reg[j] <= m_trig_reg[j];
                end
            end
        end
    endgenerate

    assign trig_ready = m_en[0];
    assign pose_valid = a_vld_reg[NUM_JOINTS-1];
    assign rot        = a_r_reg[NUM_JOINTS-1];
    assign pos        = a_t_reg[NUM_JOINTS-1];

endmodule

/* hdl/six_axis_dh_forward_kinematics.sv */
// Top level of the six-axis forward kinematics pipeline: CORDIC front end,
// link chain and the rounding output register.
// Depends on dhfk_pkg, dhfk_if, dhfk_sincos and dhfk_chain.
//
// Usage:
// - joints carries one item of six signed 16-bit joint angles, where 32768
//   is half a turn; pose returns one item per input: the 3x3 rotation in
//   Q1.16 and the tool position in Q2.16 meters, saturated.
// - An item is taken at a rising edge with valid and ready both high.
// - The pipeline holds the CORDIC front end (prep, ten stages of
//   two iterations, sign fix, link offset multiply), a multiply and a
//   sum register per link, and the output register.
// - Throughput is one item per cycle while pose.ready is high; every stage holds
//   a valid bit, loads whenever empty or its successor moves, so bubbles fill in.
// - When the receiver holds ready low, the output item stays put and the
//   pipeline keeps taking items until every stage is full; only then does
//   joints.ready fall.
// - Reset clears all valid bits; the pipeline is empty and ready at once.
`timescale 1ns / 1ps

module six_axis_dh_forward_kinematics (
    input  logic          clk,
    input  logic          rst_n,
    dhfk_joint_if.sink    joints,
    dhfk_pose_if.source   pose
);
    import dhfk_pkg::*;

    angle_vec_t angle;
    logic       trig_vld;
    logic       trig_rdy;
    trig_vec_t  trig;
    logic       lnk_vld;
    q30_mat_t   lnk_rot;
    q30w_vec_t  lnk_pos;
    logic       out_en;
    logic       out_vld_reg;
    rot_t       rot_reg [3][3];
    pos_t       pos_reg [3];

    assign angle[0] = joints.joint1_angle;
    assign angle[1] = joints.joint2_angle;
    assign angle[2] = joints.joint3_angle;
    assign angle[3] = joints.joint4_angle;
    assign angle[4] = joints.joint5_angle;
    assign angle[5] = joints.joint6_angle;

    dhfk_sincos u_sincos (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (joints.valid),
        .angle_ready (joints.ready),
        .angle       (angle),
        .trig_valid  (trig_vld),
        .trig_ready  (trig_rdy),
        .trig        (trig)
    );

    dhfk_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .trig_valid  (trig_vld),
        .trig_ready  (trig_rdy),
        .trig        (trig),
        .pose_valid  (lnk_vld),
        .pose_ready  (out_en),
        .rot         (lnk_rot),
        .pos         (lnk_pos)
    );

    // Output register: loads when empty or when the receiver takes the item.
    assign out_en = !out_vld_reg || pose.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_en)
            out_vld_reg <= lnk_vld;
    end

    // Round to Q16, clamp the rotation and saturate the position.
    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            for (int m = 0; m < 3; m++)
            begin
                for (int n = 0; n < 3; n++)
                    rot_reg[m][n] <= clamp_rot(lnk_rot[m][n]);
                pos_reg[m] <= sat_pos(lnk_pos[m]);
            end
        end
    end

    assign pose.valid  = out_vld_reg;
    assign pose.rot_00 = rot_reg[0][0];
    assign pose.rot_01 = rot_reg[0][1];
    assign pose.rot_02 = rot_reg[0][2];
    assign pose.rot_10 = rot_reg[1][0];
    assign pose.rot_11 = rot_reg[1][1];
    assign pose.rot_12 = rot_reg[1][2];
    assign pose.rot_20 = rot_reg[2][0];
    assign pose.rot_21 = rot_reg[2][1];
    assign pose.rot_22 = rot_reg[2][2];
    assign pose.pos_x  = pos_reg[0];
    assign pose.pos_y  = pos_reg[1];
    assign pose.pos_z  = pos_reg[2];

`ifndef SYNTHESIS
    // Input back-pressure only arises from a full pipeline behind a stalled output.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !joints.ready |-> (pose.valid && !pose.ready))
        else $error("input stalled while the output side can move");

    // A new output item always comes from a valid item at the chain's end.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose.valid) |-> $past(lnk_vld))
        else $error("output valid rose without an item from the link chain");
`endif

endmodule

/* tb/tb_top.sv */
// Testbench for the six-axis forward kinematics pipeline: random joint vectors
// in, poses checked against a fixed-point predictor. Depends on dhfk_pkg, dhfk_if.
`timescale 1ns / 1ps

module tb_top;
    import dhfk_pkg::*;

    typedef struct {
        logic signed [17:0] rot [9];
        logic signed [18:0] pos [3];
    } pose_rec_t;

    // Floor shift on 64-bit signed values.
    function automatic longint fshr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_q30(input longint v);
        return fshr(v + 64'sd536870912, 30);
    endfunction

    // Sine and cosine of a binary angle, Q30.
    function automatic void joint_trig(input logic [15:0] ang, output longint s,
                                       output longint c);
        logic [31:0] u;
        logic flip;
        longint x, y, z, xs, ys;
        longint atans [20];
        atans = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                  64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                  64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                  64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                  64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518};
        u = {ang, 16'h0};
        flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
        if (flip)
            u = u - 32'h80000000;
        z = longint'($signed(u));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 20; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atans[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atans[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    // Chain of six link transforms, rounded to the output formats.
    function automatic pose_rec_t predict_pose(input logic [15:0] ang [6]);
        longint r [3][3], nr [3][3], li [3][3], t [3], p [3];
        longint st, ct, acc, v;
        longint ld [6], la [6];
        int tw [6];
        pose_rec_t o;
        ld = '{136687334, 0, 0, 175986285, 124231929, 98998996};
        la = '{0, -657129996, -614502446, 0, 0, 0};
        tw = '{1, 0, 0, 1, -1, 0};
        for (int m = 0; m < 3; m++)
        begin
            t[m] = 0;
            for (int n = 0; n < 3; n++)
                r[m][n] = (m == n) ? 64'sd1073741824 : 0;
        end
        for (int j = 0; j < 6; j++)
        begin
            joint_trig(ang[j], st, ct);
            li[0][0] = ct; li[1][0] = st; li[2][0] = 0;
            if (tw[j] == 0)
            begin
                li[0][1] = -st; li[1][1] = ct; li[2][1] = 0;
                li[0][2] = 0; li[1][2] = 0; li[2][2] = 1073741824;
            end
            else if (tw[j] > 0)
            begin
                li[0][1] = 0; li[1][1] = 0; li[2][1] = 1073741824;
                li[0][2] = st; li[1][2] = -ct; li[2][2] = 0;
            end
            else
            begin
                li[0][1] = 0; li[1][1] = 0; li[2][1] = -1073741824;
                li[0][2] = -st; li[1][2] = ct; li[2][2] = 0;
            end
            p[0] = rnd_q30(la[j] * ct);
            p[1] = rnd_q30(la[j] * st);
            p[2] = ld[j];
            for (int m = 0; m < 3; m++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += r[m][k] * p[k];
                t[m] += rnd_q30(acc);
            end
            for (int m = 0; m < 3; m++)
                for (int n = 0; n < 3; n++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc += r[m][k] * li[k][n];
                    nr[m][n] = rnd_q30(acc);
                end
            r = nr;
        end
        for (int m = 0; m < 9; m++)
        begin
            v = fshr(r[m / 3][m % 3] + 8192, 14);
            if (v > 65536) v = 65536;
            if (v < -65536) v = -65536;
            o.rot[m] = v[17:0];
        end
        for (int m = 0; m < 3; m++)
        begin
            v = fshr(t[m] + 8192, 14);
            if (v > 262143) v = 262143;
            if (v < -262144) v = -262144;
            o.pos[m] = v[18:0];
        end
        return o;
    endfunction

    // Holds the poses still owed by the pipeline, oldest first.
    class pose_board;
        pose_rec_t owed [$];
        int errors = 0;
        int checked = 0;

        function void note_joints(input logic [15:0] ang [6]);
            owed.insert(owed.size(), predict_pose(ang));
        endfunction

        function void check_pose(input pose_rec_t got);
            pose_rec_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: pose item with none expected", $time);
                errors++;
                return;
            end
            want = owed.pop_front();
            checked++;
            for (int m = 0; m < 9; m++)
                if (got.rot[m] !== want.rot[m])
                begin
                    $display("%0t: rot[%0d] expected %0d actual %0d", $time, m,
                             want.rot[m], got.rot[m]);
                    errors++;
                end
            for (int m = 0; m < 3; m++)
                if (got.pos[m] !== want.pos[m])
                begin
                    $display("%0t: pos[%0d] expected %0d actual %0d", $time, m,
                             want.pos[m], got.pos[m]);
                    errors++;
                end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    dhfk_joint_if joints ();
    dhfk_pose_if  pose ();
    pose_board board;
    logic sending_done = 1'b0;
    logic stall_now = 1'b0;

    six_axis_dh_forward_kinematics i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .joints(joints),
        .pose  (pose)
    );

    always #5 clk = ~clk;

    // Drive one joint vector and wait for its acceptance.
    task automatic send_joints(input logic [15:0] ang [6]);
        joints.joint1_angle <= ang[0];
        joints.joint2_angle <= ang[1];
        joints.joint3_angle <= ang[2];
        joints.joint4_angle <= ang[3];
        joints.joint5_angle <= ang[4];
        joints.joint6_angle <= ang[5];
        joints.valid <= 1'b1;
        do
            @(posedge clk);
        while (!joints.ready);
        board.note_joints(ang);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] edges [6];
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'hFFFF};
        if ($urandom_range(0, 9) == 0)
            return edges[$urandom_range(0, 5)];
        return 16'($urandom);
    endfunction

    // Sender: corner and single-joint vectors, then random ones with random gaps.
    initial
    begin
        logic [15:0] ang [6];
        logic [15:0] corners [8];
        int gap;
        board = new();
        corners = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h3FFF,
                    16'hBFFF, 16'hFFFF};
        joints.valid = 1'b0;
        joints.joint1_angle = '0;
        joints.joint2_angle = '0;
        joints.joint3_angle = '0;
        joints.joint4_angle = '0;
        joints.joint5_angle = '0;
        joints.joint6_angle = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // All joints at the same corner angle, then one joint at a time.
        for (int c = 0; c < 8; c++)
        begin
            for (int j = 0; j < 6; j++)
                ang[j] = corners[c];
            send_joints(ang);
        end
        for (int j = 0; j < 6; j++)
        begin
            for (int k = 0; k < 6; k++)
                ang[k] = 16'h0000;
            ang[j] = 16'h8000;
            send_joints(ang);
            ang[j] = 16'h5555;
            send_joints(ang);
        end
        for (int n = 0; n < 1000; n++)
        begin
            gap = (n % 200 < 60) ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                joints.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            for (int j = 0; j < 6; j++)
                ang[j] = pick_angle();
            send_joints(ang);
        end
        joints.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Long receiver hold-off once, so the pipeline fills and backs up.
    initial
    begin
        repeat (300) @(negedge clk);
        stall_now = 1'b1;
        repeat (300) @(negedge clk);
        stall_now = 1'b0;
    end

    // Receiver: random ready gaps, check every accepted pose.
    initial
    begin
        pose_rec_t got;
        int gap;
        pose.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0 || stall_now)
            begin
                pose.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                while (stall_now) @(negedge clk);
            end
            pose.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pose.valid);
            got.rot = '{pose.rot_00, pose.rot_01, pose.rot_02, pose.rot_10,
                        pose.rot_11, pose.rot_12, pose.rot_20, pose.rot_21,
                        pose.rot_22};
            got.pos = '{pose.pos_x, pose.pos_y, pose.pos_z};
            board.check_pose(got);
            @(negedge clk);
        end
    end

    // End of run: drain, settle, report.
    initial
    begin
        wait (sending_done);
        while (board.owed.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Checked %0d poses from corner and random joint vectors,", board.checked);
        $display("including random gaps and one long output stall.");
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule

/* files.f */
hdl/dhfk_pkg.sv
hdl/dhfk_if.sv
hdl/dhfk_sincos.sv
hdl/dhfk_chain.sv
hdl/six_axis_dh_forward_kinematics.sv
tb/tb_top.sv
